[rtl/cbpn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbpn_pkg
// Shared constants for the capture buffer peak normalizer: configuration
// register map, register widths and resets, and action codes.
// ----------------------------------------------------------------------------
package cbpn_pkg;

  localparam int CH_W       = 4;
  localparam int CAP_W      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

  localparam logic [CH_W-1:0]  CH_RESET  = 4'd2;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

endpackage
`default_nettype wire

[rtl/cbpn_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbpn_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cbpn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/cbpn_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbpn_div
// Serial restoring divider: quotient = floor(mag * 2^(W-1) / divisor) for
// mag <= divisor, divisor nonzero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbpn_div #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] mag,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);

  localparam int STEP_W = $clog2(W);

  logic              running;
  logic [STEP_W-1:0] steps;
  logic [W-1:0]      rem;
  logic [W-1:0]      dvs;
  logic              int_bit;
  logic [W:0]        rem_dbl;
  logic              ge;

  always_comb begin
    int_bit = (mag >= divisor);
    rem_dbl = {rem, 1'b0};
    ge      = (rem_dbl >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        steps    <= STEP_W'(W - 1);
        dvs      <= divisor;
        rem      <= int_bit ? (mag - divisor) : mag;
        quotient <= {{(W-1){1'b0}}, int_bit};
      end else if (running) begin
        // shift in one fractional quotient bit
        rem      <= ge ? W'(rem_dbl - {1'b0, dvs}) : rem_dbl[W-1:0];
        quotient <= {quotient[W-2:0], ge};
        steps    <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/capture_buffer_peak_normalizer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// capture_buffer_peak_normalizer_core
// Capture buffer for interleaved PCM samples with running peak tracking and
// peak-normalized read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start when busy is low. action selects push (store
//   sample_in) or read (return the sample at read_index scaled so that the
//   peak maps to full scale, 2^(SAMPLE_BITS-1)).
//   Every command yields one result transaction, shown for exactly one cycle
//   with result_strobe high; the receiver cannot stall, so results are simply
//   presented and dropped after that cycle.
//   A push or an invalid read returns its result the cycle after it is taken,
//   and busy stays low, so pushes can go in every cycle. A valid read goes
//   through the sample memory read (ST_RD_WAIT) and the serial divider
//   (ST_DIV) to a registered output; busy stays high until its result is
//   presented, so no other command is taken meanwhile. A read at zero peak
//   skips the divider. Pushes are dropped once channels * capacity_frames
//   samples (capped at MAX_SAMPLES) are stored; done_res reports that limit.
//   Configuration is written through cfg_we/cfg_index/cfg_data only while
//   idle, a rule on the user that the block does not enforce. Reset clears
//   the sample count, the peak and the result strobe and loads the register
//   defaults (2 channels, 4096 frames). The sample memory is not cleared:
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
module capture_buffer_peak_normalizer_core #(
  parameter int MAX_SAMPLES = 8192,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [cbpn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cbpn_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               action,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_in,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]     read_index,
  output logic                                    result_strobe,
  output logic                                    accepted,
  output logic                                    done_res,
  output logic                                    read_valid,
  output logic signed [SAMPLE_BITS:0]             normalized_sample,
  output logic [SAMPLE_BITS-1:0]                  peak_level,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]        sample_count
);

  import cbpn_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SB     = SAMPLE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_DIV
  } state_t;

  state_t state;

  // configuration and block state
  logic [CH_W-1:0]  channels;
  logic [CAP_W-1:0] capacity_frames;
  logic [CNT_W-1:0] stored_count;
  logic [SB-1:0]    peak_abs;
  logic             neg;

  // derived signals
  logic [CH_W-1:0]       ch_eff;
  logic [CAP_W-1:0]      cap_eff;
  logic [CH_W+CAP_W-1:0] lim_prod;
  logic [CNT_W-1:0]      limit;
  logic                  full;
  logic                  take;
  logic                  push_ok;
  logic                  idx_ok;
  logic [SB:0]           in_neg;
  logic [SB-1:0]         in_mag;
  logic [CNT_W-1:0]      stored_count_next;
  logic [SB-1:0]         peak_abs_next;
  logic                  done_next;

  logic signed [SB-1:0]  rd_sample;
  logic [SB:0]           rd_neg;
  logic [SB-1:0]         rd_mag;
  logic                  div_start;
  logic                  div_done;
  logic [SB-1:0]         div_q;
  logic [SB:0]           q_ext;

  assign busy = (state != ST_IDLE);
  assign take = start && !busy;

  // Treat zero registers as one; cap the limit at the store depth.
  always_comb begin
    ch_eff   = (channels == '0) ? CH_W'(1) : channels;
    cap_eff  = (capacity_frames == '0) ? CAP_W'(1) : capacity_frames;
    lim_prod = (CH_W + CAP_W)'(ch_eff) * (CH_W + CAP_W)'(cap_eff);
    limit    = (32'(lim_prod) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                  : CNT_W'(lim_prod);
    full     = (stored_count >= limit);
  end

  // Push path: store at the current count and fold the magnitude into the peak.
  always_comb begin
    push_ok = take && (action == ACT_PUSH) && !full;
    idx_ok  = (CNT_W'(read_index) < stored_count);
    in_neg  = -{sample_in[SB-1], sample_in};
    in_mag  = sample_in[SB-1] ? in_neg[SB-1:0] : sample_in;
    stored_count_next = stored_count;
    peak_abs_next     = peak_abs;
    if (push_ok) begin
      stored_count_next = stored_count + 1'b1;
      if (in_mag > peak_abs) begin
        peak_abs_next = in_mag;
      end
    end
    done_next = (stored_count_next >= limit);
  end

  cbpn_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (stored_count[ADDR_W-1:0]),
    .wdata (sample_in),
    .re    (take && (action == ACT_READ) && idx_ok),
    .raddr (read_index),
    .rdata (rd_sample)
  );

  // Read path: magnitude of the stored sample goes to the divider.
  always_comb begin
    rd_neg    = -{rd_sample[SB-1], rd_sample};
    rd_mag    = rd_sample[SB-1] ? rd_neg[SB-1:0] : rd_sample;
    div_start = (state == ST_RD_WAIT) && (peak_abs != '0);
    q_ext     = {1'b0, div_q};
  end

  cbpn_div #(
    .W (SB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mag      (rd_mag),
    .divisor  (peak_abs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      result_strobe   <= 1'b0;
      stored_count    <= '0;
      peak_abs        <= '0;
      channels        <= CH_RESET;
      capacity_frames <= CAP_RESET;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNELS: channels        <= cfg_data[CH_W-1:0];
          REG_CAPACITY: capacity_frames <= cfg_data[CAP_W-1:0];
          default:      ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            stored_count <= stored_count_next;
            peak_abs     <= peak_abs_next;
            if ((action == ACT_READ) && idx_ok) begin
              // wait for the memory read
              state <= ST_RD_WAIT;
            end else begin
              // push or out-of-range read: answer right away
              result_strobe     <= 1'b1;
              accepted          <= push_ok;
              read_valid        <= 1'b0;
              normalized_sample <= '0;
              done_res          <= done_next;
              peak_level        <= peak_abs_next;
              sample_count      <= stored_count_next;
            end
          end
        end
        ST_RD_WAIT: begin
          neg <= rd_sample[SB-1];
          if (peak_abs == '0) begin
            // silence: hand back the raw sample
            state             <= ST_IDLE;
            result_strobe     <= 1'b1;
            accepted          <= 1'b0;
            read_valid        <= 1'b1;
            normalized_sample <= {rd_sample[SB-1], rd_sample};
            done_res          <= full;
            peak_level        <= peak_abs;
            sample_count      <= stored_count;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state             <= ST_IDLE;
            result_strobe     <= 1'b1;
            accepted          <= 1'b0;
            read_valid        <= 1'b1;
            normalized_sample <= neg ? -q_ext : q_ext;
            done_res          <= full;
            peak_level        <= peak_abs;
            sample_count      <= stored_count;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/cbpn_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbpn_checker
// Port-level checks for the capture buffer peak normalizer, bound to the top.
// ----------------------------------------------------------------------------
module cbpn_checker #(
  parameter int MAX_SAMPLES = 8192,
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              result_strobe,
  input wire logic                              accepted,
  input wire logic                              read_valid,
  input wire logic signed [SAMPLE_BITS:0]       normalized_sample,
  input wire logic [$clog2(MAX_SAMPLES+1)-1:0]  sample_count
);

  // a taken command either answers next cycle or holds the block busy
  a_take_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_strobe || busy))
    else $error("taken command neither answered nor busy");

  // leaving busy always delivers the read result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_strobe)
    else $error("busy dropped without a result");

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !(accepted && read_valid))
    else $error("result marks both push and read");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !read_valid) |-> (normalized_sample == '0))
    else $error("nonzero sample on a result without a valid read");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && read_valid) |-> (sample_count != '0))
    else $error("valid read with an empty buffer");

endmodule

bind capture_buffer_peak_normalizer_core cbpn_checker #(
  .MAX_SAMPLES (MAX_SAMPLES),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cbpn_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .result_strobe     (result_strobe),
  .accepted          (accepted),
  .read_valid        (read_valid),
  .normalized_sample (normalized_sample),
  .sample_count      (sample_count)
);
`default_nettype wire
